// File: src/fwf_pkg.sv
// fwf_pkg: shared widths, coefficient reset values and cell control type
// for the FIR filter with flush. No dependencies.
package fwf_pkg;

  localparam int DATA_W = 16;
  localparam int COEF_W = 16;
  localparam int PROD_W = DATA_W + COEF_W;
  localparam int NREG   = 8;
  localparam int IDX_W  = $clog2(NREG);
  localparam int FRAC   = 14;
  // products plus growth for NREG terms, plus the rounding offset
  localparam int ACC_W  = PROD_W + $clog2(NREG) + 1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'((1 <<< (DATA_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO     = -(ACC_W'(1) <<< (DATA_W - 1));

  // Q2.14 taps: 0.25, -0.5, 0.25, rest zero
  localparam logic signed [COEF_W-1:0] COEF_RESET [NREG] = '{
    16'sh1000, 16'shE000, 16'sh1000, 16'sh0000,
    16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000
  };

  typedef struct packed {
    logic shift;  // load tap from left neighbor
    logic clear;  // zero the tap
    logic mul;    // capture coef * tap
    logic pass;   // take product from right neighbor
  } fwf_ctl_t;

endpackage

// File: src/fwf_cell.sv
// fwf_cell: one tap of the delay line with its multiplier and product stage.
// Depends on fwf_pkg.
module fwf_cell import fwf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  fwf_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [DATA_W-1:0] x_in,
  input  logic signed [PROD_W-1:0] prod_in,
  output logic signed [DATA_W-1:0] x,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      x <= '0;
    end else if (ctl.shift) begin
      x <= x_in;
    end
  end

  // products drain toward cell 0, one position per cycle
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= PROD_W'(coef) * PROD_W'(x);
    end else if (ctl.pass) begin
      prod <= prod_in;
    end
  end

endmodule

// File: src/fir_filter_with_flush.sv
// fir_filter_with_flush: direct-form FIR, a row of tap cells and one accumulator.
// Each sample passes through MUL, ACC and RND, and a new sample is taken only
// in idle, after the product chain has drained one tap per cycle into the
// single accumulator and the result has gone to the output register. An
// end-of-signal request holds off input until TAPS-1 zero-padded tail outputs follow it.
// Reset (rst, synchronous): delay line zeroed, taps to 0.25/-0.5/0.25/0..., idle.
module fir_filter_with_flush import fwf_pkg::*; #(
  parameter int TAPS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_ready,
  input  logic signed [DATA_W-1:0] sample_in,
  input  logic                     end_of_signal,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic signed [DATA_W-1:0] sample_out,
  output logic                     last_out,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_index,
  input  logic signed [COEF_W-1:0] wr_data
);

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TAPS - 1);

  // MUL: every cell multiplies at once. ACC: products shift toward cell 0
  // and are summed one per cycle. RND: round, saturate, hand to output reg.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_RND  = 4'b1000
  } state_t;

  state_t state;
  logic signed [COEF_W-1:0] coef [NREG];
  logic signed [DATA_W-1:0] tap  [TAPS];
  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [DATA_W-1:0] head_x;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic signed [ACC_W-1:0]  rnd_val;
  logic signed [DATA_W-1:0] sat_val;
  logic [CNT_W-1:0]         step;
  logic [CNT_W-1:0]         tail_cnt;  // zero-padded outputs still owed
  logic                     eos;       // current request ends the signal
  logic                     take_in;
  logic                     rnd_fire;
  logic                     tap_any;
  fwf_ctl_t                 ctl;

  // ---------------------------------------------------------------------
  // Tap weights: plain write port, no read-back
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) begin
        coef[i] <= COEF_RESET[i];
      end
    end else if (wr_en) begin
      coef[wr_index] <= wr_data;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and cell control
  // ---------------------------------------------------------------------
  assign sample_ready = (state == ST_IDLE);
  assign take_in      = sample_valid && sample_ready;
  // output register frees up this cycle or is already empty
  assign rnd_fire     = (state == ST_RND) && (!result_valid || result_ready);

  // new sample enters from the left; tail outputs shift in zeros
  assign head_x = (state == ST_IDLE) ? sample_in : '0;

  always_comb begin
    ctl.shift = take_in || (rnd_fire && (tail_cnt != '0));
    ctl.clear = rnd_fire && (tail_cnt == '0) && eos;
    ctl.mul   = (state == ST_MUL);
    ctl.pass  = (state == ST_ACC);
  end

  // ---------------------------------------------------------------------
  // Row of tap cells; cell j holds the sample delayed by j
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    logic signed [DATA_W-1:0] x_left;
    logic signed [PROD_W-1:0] p_right;

    if (j == 0) begin : g_head
      assign x_left = head_x;
    end else begin : g_body
      assign x_left = tap[j-1];
    end

    if (j == TAPS - 1) begin : g_end
      assign p_right = '0;
    end else begin : g_link
      assign p_right = prod[j+1];
    end

    fwf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .coef    (coef[j]),
      .x_in    (x_left),
      .prod_in (p_right),
      .x       (tap[j]),
      .prod    (prod[j])
    );
  end

  // ---------------------------------------------------------------------
  // Round half up at bit 14, then saturate to 16 bits
  // ---------------------------------------------------------------------
  always_comb begin
    rnd_sum = acc + ROUND_HALF;
    rnd_val = rnd_sum >>> FRAC;
    if (rnd_val > SAT_HI) begin
      sat_val = SAT_HI[DATA_W-1:0];
    end else if (rnd_val < SAT_LO) begin
      sat_val = SAT_LO[DATA_W-1:0];
    end else begin
      sat_val = rnd_val[DATA_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      tail_cnt <= '0;
      eos      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take_in) begin
            eos      <= end_of_signal;
            tail_cnt <= end_of_signal ? LAST_STEP : '0;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          step  <= '0;
          state <= ST_ACC;
        end
        ST_ACC: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= ST_RND;
          end
        end
        ST_RND: begin
          if (rnd_fire) begin
            if (tail_cnt != '0) begin
              tail_cnt <= tail_cnt - 1'b1;
              state    <= ST_MUL;
            end else begin
              eos   <= 1'b0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // accumulator: cleared while cells multiply, one product per cycle after
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      acc <= '0;
    end else if (state == ST_ACC) begin
      acc <= acc + ACC_W'(prod[0]);
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (rnd_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rnd_fire) begin
      sample_out <= sat_val;
      last_out   <= eos && (tail_cnt == '0);
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  always_comb begin
    tap_any = 1'b0;
    for (int i = 0; i < TAPS; i++) begin
      tap_any = tap_any | (tap[i] != '0);
    end
  end

  // tail outputs are only owed for an end-of-signal request
  a_tail_needs_eos: assert property (@(posedge clk) disable iff (rst)
    (tail_cnt != '0) |-> eos)
    else $error("tail count set without end of signal");

  // the delay line is empty once the last tail output is handed off
  a_clear_after_tail: assert property (@(posedge clk) disable iff (rst)
    (rnd_fire && eos && (tail_cnt == '0)) |=> !tap_any)
    else $error("delay line not cleared after flush");

  // an accepted sample always starts a multiply pass
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    take_in |=> (state == ST_MUL))
    else $error("sample accepted without starting a pass");

endmodule
